@@ sv/pbl_pkg.sv @@
`default_nettype none

package pbl_pkg;

    // Colour table depth (2 .. 256) and its index width
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

    localparam int PADDR_W = 5;
    localparam int SUM_W   = 17;   // origin + count, no wrap
    localparam int PROD_W  = 33;   // row_pitch * (origin_top + row)

    typedef enum logic [2:0] {
        REG_DEPTH_MODE   = 3'd0,
        REG_FRAME_BASE   = 3'd1,
        REG_ROW_PITCH    = 3'd2,
        REG_ORIGIN_LEFT  = 3'd3,
        REG_ORIGIN_TOP   = 3'd4,
        REG_IMAGE_WIDTH  = 3'd5,
        REG_IMAGE_HEIGHT = 3'd6
    } cfg_reg_t;

    // depth_mode codes; 5..7 are undefined and produce no transaction
    localparam logic [2:0] DEPTH_INDEX8 = 3'd0;
    localparam logic [2:0] DEPTH_RGB555 = 3'd1;
    localparam logic [2:0] DEPTH_RGB565 = 3'd2;
    localparam logic [2:0] DEPTH_RGB24  = 3'd3;
    localparam logic [2:0] DEPTH_RGB32  = 3'd4;

    localparam logic [2:0]  DEPTH_MODE_RST   = DEPTH_RGB32;
    localparam logic [15:0] IMAGE_SIZE_RST   = 16'd1;

    // Raster position of the current pixel, as handed to the pipeline
    typedef struct packed {
        logic [SUM_W-1:0] row_sum;
        logic [SUM_W-1:0] col_sum;
        logic             last;
    } pos_t;

endpackage

`default_nettype wire

@@ sv/pbl_palette_ram.sv @@
`default_nettype none

module pbl_palette_ram
    import pbl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [PAL_AW-1:0] wr_addr,
    input  wire logic [23:0]       wr_data,
    input  wire logic              rd_en,
    input  wire logic [PAL_AW-1:0] rd_addr,
    output logic      [23:0]       rd_data
);

    logic [23:0] mem [PAL_ENTRIES];
    logic [23:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/pbl_raster_ctr.sv @@
`default_nettype none

module pbl_raster_ctr
    import pbl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [15:0] origin_left,
    input  wire logic [15:0] origin_top,
    input  wire logic [15:0] image_width,
    input  wire logic [15:0] image_height,
    output pos_t             pos
);

    logic [15:0]      col_reg;
    logic [15:0]      col_next;
    logic [15:0]      row_reg;
    logic [15:0]      row_next;
    logic [SUM_W-1:0] span_w;
    logic [SUM_W-1:0] span_h;
    logic             last_col;
    logic             last_row;

    // a size of zero means 65536
    assign span_w = (image_width  == 16'd0) ? 17'h1_0000 : {1'b0, image_width};
    assign span_h = (image_height == 16'd0) ? 17'h1_0000 : {1'b0, image_height};

    assign last_col = ({1'b0, col_reg} + 17'd1) >= span_w;
    assign last_row = ({1'b0, row_reg} + 17'd1) >= span_h;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (last_col)
            begin
                col_next = 16'd0;
                row_next = last_row ? 16'd0 : row_reg + 16'd1;
            end
            else
            begin
                col_next = col_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= 16'd0;
            row_reg <= 16'd0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.row_sum = {1'b0, origin_top}  + {1'b0, row_reg};
    assign pos.col_sum = {1'b0, origin_left} + {1'b0, col_reg};
    assign pos.last    = last_col && last_row;

endmodule

`default_nettype wire

@@ sv/palette_indexed_blitter_top.sv @@
`default_nettype none

// Palette-indexed blitter: 8-bit pixel indices in, frame-buffer write transactions out.
// Pipeline: three register stages, S1, S2 and the output register, lie between the
// acceptance of an input transaction and the presentation of its write.
// Throughput: one item per cycle while out_stall is low; the colour table RAM has one read
// and one write port, and the 16x17 pitch multiply is registered in S2.
// Reset (rst_n, async, active low) clears counters and pipeline valids and restores
// config defaults; the colour table is not cleared and is undefined until written.

module palette_indexed_blitter_top
    import pbl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // APB-style configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,

    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               opcode,
    input  wire logic [7:0]         entry_index,
    input  wire logic [7:0]         red_in,
    input  wire logic [7:0]         green_in,
    input  wire logic [7:0]         blue_in,
    input  wire logic [7:0]         pixel_index,

    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [31:0]        write_address,
    output logic      [31:0]        write_data,
    output logic      [2:0]         byte_count,
    output logic                    last_pixel
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]  depth_mode_reg;
    logic [31:0] frame_base_reg;
    logic [15:0] row_pitch_reg;
    logic [15:0] origin_left_reg;
    logic [15:0] origin_top_reg;
    logic [15:0] image_width_reg;
    logic [15:0] image_height_reg;

    logic        cfg_wr;
    cfg_reg_t    cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg   <= DEPTH_MODE_RST;
            frame_base_reg   <= 32'd0;
            row_pitch_reg    <= 16'd0;
            origin_left_reg  <= 16'd0;
            origin_top_reg   <= 16'd0;
            image_width_reg  <= IMAGE_SIZE_RST;
            image_height_reg <= IMAGE_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_DEPTH_MODE:   depth_mode_reg   <= pwdata[2:0];
                REG_FRAME_BASE:   frame_base_reg   <= pwdata;
                REG_ROW_PITCH:    row_pitch_reg    <= pwdata[15:0];
                REG_ORIGIN_LEFT:  origin_left_reg  <= pwdata[15:0];
                REG_ORIGIN_TOP:   origin_top_reg   <= pwdata[15:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[15:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[15:0];
                default: ;  // address beyond the map: ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_DEPTH_MODE:   prdata = {29'd0, depth_mode_reg};
            REG_FRAME_BASE:   prdata = frame_base_reg;
            REG_ROW_PITCH:    prdata = {16'd0, row_pitch_reg};
            REG_ORIGIN_LEFT:  prdata = {16'd0, origin_left_reg};
            REG_ORIGIN_TOP:   prdata = {16'd0, origin_top_reg};
            REG_IMAGE_WIDTH:  prdata = {16'd0, image_width_reg};
            REG_IMAGE_HEIGHT: prdata = {16'd0, image_height_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    //   S1: table read in flight, raster position captured
    //   S2: colour read back, pitch product registered
    //   out: packed write transaction held until taken
    // Each stage advances when it is empty or its successor advances.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic adv_out;
    logic adv2;
    logic adv1;
    logic in_acc;
    logic pix_acc;
    logic pal_wr;

    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv2     = !s2_valid_reg || adv_out;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;

    assign in_acc  = in_valid && adv1;
    assign pix_acc = in_acc && opcode;
    // entries beyond the table are dropped
    assign pal_wr  = in_acc && !opcode && ({1'b0, entry_index} < 9'(PAL_ENTRIES));

    // ------------------------------------------------------------------
    // Colour table and raster counters
    // ------------------------------------------------------------------
    logic [23:0] colour_rd;
    pos_t        pos;

    pbl_palette_ram u_ram (
        .clk     (clk),
        .wr_en   (pal_wr),
        .wr_addr (entry_index[PAL_AW-1:0]),
        .wr_data ({red_in, green_in, blue_in}),
        .rd_en   (pix_acc),
        .rd_addr (pixel_index[PAL_AW-1:0]),
        .rd_data (colour_rd)
    );

    pbl_raster_ctr u_ctr (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (pix_acc),
        .origin_left  (origin_left_reg),
        .origin_top   (origin_top_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .pos          (pos)
    );

    // ------------------------------------------------------------------
    // S1
    // ------------------------------------------------------------------
    pos_t       s1_pos_reg;
    logic [7:0] s1_pix_reg;
    logic       s1_oob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s1_valid_reg <= pix_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_pos_reg <= pos;
            s1_pix_reg <= pixel_index;
            s1_oob_reg <= ({1'b0, pixel_index} >= 9'(PAL_ENTRIES));
        end
    end

    // ------------------------------------------------------------------
    // S2
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [23:0]       s2_colour_reg;
    logic [SUM_W-1:0]  s2_col_reg;
    logic [7:0]        s2_pix_reg;
    logic              s2_last_reg;
    logic              s2_load;

    assign prod_next = PROD_W'(row_pitch_reg) * PROD_W'(s1_pos_reg.row_sum);
    assign s2_load   = adv2 && s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_prod_reg   <= prod_next;
            s2_colour_reg <= s1_oob_reg ? 24'd0 : colour_rd;
            s2_col_reg    <= s1_pos_reg.col_sum;
            s2_pix_reg    <= s1_pix_reg;
            s2_last_reg   <= s1_pos_reg.last;
        end
    end

    // ------------------------------------------------------------------
    // Pack and address, into the output register
    // ------------------------------------------------------------------
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [31:0] data_next;
    logic [2:0]  bytes_next;
    logic [31:0] col_off;
    logic        mode_ok;
    logic [31:0] addr_next;
    logic        out_load;

    assign r8 = s2_colour_reg[23:16];
    assign g8 = s2_colour_reg[15:8];
    assign b8 = s2_colour_reg[7:0];

    always_comb
    begin
        data_next  = 32'd0;
        bytes_next = 3'd0;
        col_off    = 32'd0;
        mode_ok    = 1'b1;
        unique case (depth_mode_reg)
            DEPTH_INDEX8:
            begin
                data_next  = {24'd0, s2_pix_reg};
                bytes_next = 3'd1;
                col_off    = 32'(s2_col_reg);
            end
            DEPTH_RGB555:
            begin
                data_next  = {17'd0, r8[7:3], g8[7:3], b8[7:3]};
                bytes_next = 3'd2;
                col_off    = 32'({s2_col_reg, 1'b0});
            end
            DEPTH_RGB565:
            begin
                data_next  = {16'd0, r8[7:3], g8[7:2], b8[7:3]};
                bytes_next = 3'd2;
                col_off    = 32'({s2_col_reg, 1'b0});
            end
            DEPTH_RGB24:
            begin
                data_next  = {8'd0, r8, g8, b8};
                bytes_next = 3'd3;
                col_off    = 32'({s2_col_reg, 1'b0}) + 32'(s2_col_reg);
            end
            DEPTH_RGB32:
            begin
                data_next  = {8'd0, r8, g8, b8};
                bytes_next = 3'd4;
                col_off    = 32'({s2_col_reg, 2'b00});
            end
            default:
            begin
                mode_ok = 1'b0;  // undefined depth: pixel consumed, nothing written
            end
        endcase
    end

    assign addr_next = frame_base_reg + s2_prod_reg[31:0] + col_off;
    assign out_load  = adv_out && s2_valid_reg;

    logic [31:0] out_addr_reg;
    logic [31:0] out_data_reg;
    logic [2:0]  out_bytes_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= s2_valid_reg && mode_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_addr_reg  <= addr_next;
            out_data_reg  <= data_next;
            out_bytes_reg <= bytes_next;
            out_last_reg  <= s2_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_address = out_addr_reg;
    assign write_data    = out_data_reg;
    assign byte_count    = out_bytes_reg;
    assign last_pixel    = out_last_reg;

endmodule

`default_nettype wire
